@@ rtl/sslb_pkg.sv @@
// ----------------------------------------------------------------------------
// sslb_pkg
// Types, codes and constants shared by the sensor status LED blinker.
// ----------------------------------------------------------------------------
package sslb_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 64;
	localparam int unsigned TICK_W         = 32;
	localparam int unsigned RES_W          = 5;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned PROD_W         = 36;
	localparam int unsigned N_SRC          = 4;

	localparam logic [PROD_W-1:0] US_PER_SEC = PROD_W'(1000000);

	localparam logic [RES_W-1:0] SLOW_PERIOD = RES_W'(20);
	localparam logic [RES_W-1:0] SLOW_ON     = RES_W'(10);
	localparam logic [RES_W-1:0] SLOW_OFS_Y  = RES_W'(7);
	localparam logic [RES_W-1:0] SLOW_OFS_R  = RES_W'(14);
	localparam logic [RES_W-1:0] FAST_PERIOD = RES_W'(5);
	localparam logic [RES_W-1:0] FAST_ON     = RES_W'(2);
	localparam logic [RES_W-1:0] FUS_PERIOD  = RES_W'(3);
	localparam logic [RES_W-1:0] FUS_ON      = RES_W'(1);
	localparam logic [RES_W-1:0] TEST_PERIOD = RES_W'(6);
	localparam logic [RES_W-1:0] TEST_Y_LO   = RES_W'(2);
	localparam logic [RES_W-1:0] TEST_R_LO   = RES_W'(4);

	localparam logic [31:0] FRESH_WIN_RST   = 32'd500000;
	localparam logic [31:0] STARTUP_WIN_RST = 32'd3000000;

	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ALL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_GREEN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_YELLOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRESH_WIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WIN   = 3'd5;

	typedef enum logic [1:0] {
		MODE_TEST    = 2'd0,
		MODE_STARTUP = 2'd1,
		MODE_SENSOR  = 2'd2
	} sslb_mode_t;

	typedef struct packed {
		logic [63:0] now_us;
		logic        accel0_new;
		logic [63:0] accel0_time;
		logic        accel1_new;
		logic [63:0] accel1_time;
		logic        mag_new;
		logic [63:0] mag_time;
		logic        fusion_new;
		logic [63:0] fusion_time;
		logic        test_request;
		logic [15:0] test_seconds;
	} sslb_in_t;

	typedef struct packed {
		logic       green_level;
		logic       yellow_level;
		logic       red_level;
		sslb_mode_t display_mode;
		logic [3:0] fresh_flags;
	} sslb_out_t;

	typedef struct packed {
		logic        inv_all;
		logic        inv_green;
		logic        inv_yellow;
		logic        inv_red;
		logic [31:0] fresh_win;
		logic [31:0] startup_win;
	} sslb_cfg_t;

	typedef struct packed {
		logic slow_g;
		logic slow_y;
		logic slow_r;
		logic fast;
		logic fus;
		logic test_g;
		logic test_y;
		logic test_r;
	} sslb_blink_t;

	function automatic logic [RES_W-1:0] res_next(input logic [RES_W-1:0] cur,
			input logic [RES_W-1:0] modulus, input logic wrap);
		logic [RES_W-1:0] nxt;
		nxt = cur + RES_W'(1);
		if (wrap || nxt == modulus) begin
			nxt = '0;
		end
		return nxt;
	endfunction

endpackage

@@ rtl/sslb_phase.sv @@
// ----------------------------------------------------------------------------
// sslb_phase
// Wrapping tick counter with residue counters; gives blink bits for next count.
// ----------------------------------------------------------------------------
module sslb_phase (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	output sslb_pkg::sslb_blink_t     blink
);
	import sslb_pkg::*;

	logic [TICK_W-1:0] tick_q, tick_nx;
	logic [RES_W-1:0]  sg_q, sy_q, sr_q, f5_q, f3_q, t6_q;
	logic [RES_W-1:0]  sg_nx, sy_nx, sr_nx, f5_nx, f3_nx, t6_nx;
	logic              wrap0, wrap_y, wrap_r;

	// residues follow the 32-bit count, so they restart where the sum wraps
	always_comb begin
		tick_nx = tick_q + TICK_W'(1);
		wrap0   = (tick_nx == '0);
		wrap_y  = ((tick_nx + TICK_W'(SLOW_OFS_Y)) == '0);
		wrap_r  = ((tick_nx + TICK_W'(SLOW_OFS_R)) == '0);
		sg_nx   = res_next(sg_q, SLOW_PERIOD, wrap0);
		sy_nx   = res_next(sy_q, SLOW_PERIOD, wrap_y);
		sr_nx   = res_next(sr_q, SLOW_PERIOD, wrap_r);
		f5_nx   = res_next(f5_q, FAST_PERIOD, wrap0);
		f3_nx   = res_next(f3_q, FUS_PERIOD, wrap0);
		t6_nx   = res_next(t6_q, TEST_PERIOD, wrap0);
	end

	always_comb begin
		blink.slow_g = (sg_nx < SLOW_ON);
		blink.slow_y = (sy_nx < SLOW_ON);
		blink.slow_r = (sr_nx < SLOW_ON);
		blink.fast   = (f5_nx < FAST_ON);
		blink.fus    = (f3_nx < FUS_ON);
		blink.test_g = (t6_nx < TEST_Y_LO);
		blink.test_y = (t6_nx >= TEST_Y_LO) && (t6_nx < TEST_R_LO);
		blink.test_r = (t6_nx >= TEST_R_LO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			sg_q   <= '0;
			sy_q   <= SLOW_OFS_Y;
			sr_q   <= SLOW_OFS_R;
			f5_q   <= '0;
			f3_q   <= '0;
			t6_q   <= '0;
		end else if (adv) begin
			tick_q <= tick_nx;
			sg_q   <= sg_nx;
			sy_q   <= sy_nx;
			sr_q   <= sr_nx;
			f5_q   <= f5_nx;
			f3_q   <= f3_nx;
			t6_q   <= t6_nx;
		end
	end

endmodule

@@ rtl/sslb_core.sv @@
// ----------------------------------------------------------------------------
// sslb_core
// Timestamp state, freshness, mode selection and LED drive for one tick.
// ----------------------------------------------------------------------------
module sslb_core #(
	parameter int unsigned TIME_WIDTH = sslb_pkg::TIME_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  sslb_pkg::sslb_in_t      beat,
	input  logic [TIME_WIDTH-1:0]   test_len,
	input  sslb_pkg::sslb_cfg_t     cfg,
	input  sslb_pkg::sslb_blink_t   blink,
	output sslb_pkg::sslb_out_t     res
);
	import sslb_pkg::*;

	logic [TIME_WIDTH-1:0] last_q [N_SRC];
	logic [TIME_WIDTH-1:0] last_nx [N_SRC];
	logic [TIME_WIDTH-1:0] stamp [N_SRC];
	logic [N_SRC-1:0]      stamp_new;
	logic [TIME_WIDTH-1:0] age [N_SRC];
	logic [N_SRC-1:0]      fresh;
	logic [TIME_WIDTH-1:0] now, start_q, start_eff, start_age;
	logic [TIME_WIDTH-1:0] until_q, until_nx;
	logic                  started_q;
	logic                  test_on, startup_on;
	logic                  g, y, r;
	sslb_mode_t            mode;

	always_comb begin
		now       = beat.now_us[TIME_WIDTH-1:0];
		stamp[0]  = beat.accel0_time[TIME_WIDTH-1:0];
		stamp[1]  = beat.accel1_time[TIME_WIDTH-1:0];
		stamp[2]  = beat.mag_time[TIME_WIDTH-1:0];
		stamp[3]  = beat.fusion_time[TIME_WIDTH-1:0];
		stamp_new = {beat.fusion_new, beat.mag_new, beat.accel1_new, beat.accel0_new};
		for (int i = 0; i < N_SRC; i++) begin
			last_nx[i] = stamp_new[i] ? stamp[i] : last_q[i];
			age[i]     = now - last_nx[i];
			fresh[i]   = (age[i] < TIME_WIDTH'(cfg.fresh_win));
		end
		start_eff  = started_q ? start_q : now;
		start_age  = now - start_eff;
		startup_on = (start_age < TIME_WIDTH'(cfg.startup_win));
		until_nx   = beat.test_request ? (now + test_len) : until_q;
		test_on    = (until_nx > now);
	end

	always_comb begin
		if (test_on) begin
			g    = blink.test_g;
			y    = blink.test_y;
			r    = blink.test_r;
			mode = MODE_TEST;
		end else if (startup_on) begin
			g    = blink.slow_g;
			y    = blink.slow_y;
			r    = blink.slow_r;
			mode = MODE_STARTUP;
		end else begin
			g    = fresh[3] ? blink.fus : (fresh[0] ? blink.fast : blink.slow_g);
			y    = fresh[3] ? blink.fus : (fresh[1] ? blink.fast : blink.slow_y);
			r    = fresh[2] ? blink.fast : blink.slow_r;
			mode = MODE_SENSOR;
		end
		res.green_level  = g ^ cfg.inv_all ^ cfg.inv_green;
		res.yellow_level = y ^ cfg.inv_all ^ cfg.inv_yellow;
		res.red_level    = r ^ cfg.inv_all ^ cfg.inv_red;
		res.display_mode = mode;
		res.fresh_flags  = fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_SRC; i++) begin
				last_q[i] <= '0;
			end
			until_q   <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < N_SRC; i++) begin
				last_q[i] <= last_nx[i];
			end
			until_q   <= until_nx;
			started_q <= 1'b1;
		end
	end

	// first-tick time, no reset
	always_ff @(posedge clk) begin
		if (adv && !started_q) begin
			start_q <= now;
		end
	end

endmodule

@@ rtl/sensor_status_led_blinker.sv @@
// ----------------------------------------------------------------------------
// sensor_status_led_blinker
// Three-LED status driver: tick input register, evaluation, status register.
// ----------------------------------------------------------------------------
// Path: a tick beat is registered in the input register, then in the status
//   register, which holds it while the status output stalls.
// Throughput: one tick per cycle; the input register holds one beat while the
//   status register stalls.
// Reset: arst_n clears counters, timestamps, test end and config to defaults;
//   the start time is latched on the first tick and needs no reset.
module sensor_status_led_blinker #(
	parameter int unsigned TIME_WIDTH = sslb_pkg::TIME_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick_valid,
	output logic                               tick_stall,
	input  sslb_pkg::sslb_in_t                 tick,
	output logic                               status_valid,
	input  logic                               status_stall,
	output sslb_pkg::sslb_out_t                status,
	input  logic                               cfg_we,
	input  logic [sslb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sslb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sslb_pkg::*;

	sslb_in_t              beat_s1;
	logic [TIME_WIDTH-1:0] len_s1;
	logic                  valid_s1;
	logic [PROD_W-1:0]     prod;
	logic                  adv, take;
	sslb_cfg_t             cfg_q;
	sslb_blink_t           blink;
	sslb_out_t             res, status_q;
	logic                  status_valid_q;

	assign adv          = valid_s1 && (!status_valid_q || !status_stall);
	assign tick_stall   = valid_s1 && status_valid_q && status_stall;
	assign take         = tick_valid && !tick_stall;
	assign prod         = PROD_W'(tick.test_seconds) * US_PER_SEC;
	assign status_valid = status_valid_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_all     <= 1'b0;
			cfg_q.inv_green   <= 1'b0;
			cfg_q.inv_yellow  <= 1'b0;
			cfg_q.inv_red     <= 1'b0;
			cfg_q.fresh_win   <= FRESH_WIN_RST;
			cfg_q.startup_win <= STARTUP_WIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INVERT_ALL:    cfg_q.inv_all     <= cfg_data[0];
				CFG_INVERT_GREEN:  cfg_q.inv_green   <= cfg_data[0];
				CFG_INVERT_YELLOW: cfg_q.inv_yellow  <= cfg_data[0];
				CFG_INVERT_RED:    cfg_q.inv_red     <= cfg_data[0];
				CFG_FRESH_WIN:     cfg_q.fresh_win   <= cfg_data;
				CFG_STARTUP_WIN:   cfg_q.startup_win <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= tick;
			len_s1  <= TIME_WIDTH'(prod);
		end
	end

	sslb_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.blink  (blink)
	);

	sslb_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.beat     (beat_s1),
		.test_len (len_s1),
		.cfg      (cfg_q),
		.blink    (blink),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (adv) begin
			status_valid_q <= 1'b1;
		end else if (!status_stall) begin
			status_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= res;
		end
	end

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && status_valid && status_stall))
		else $error("tick stalled without a held status beat");

	a_adv_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> status_valid)
		else $error("evaluated tick produced no status beat");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> (status.display_mode == MODE_TEST ||
			status.display_mode == MODE_STARTUP || status.display_mode == MODE_SENSOR))
		else $error("illegal display mode on status beat");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(status_valid && status_stall) |=> status_valid)
		else $error("stalled status beat dropped");
`endif

endmodule
